[design/hbt_pkg.sv]
package hbt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int REQ_W  = 3;
   localparam int MAC_W  = 48;
   localparam int IP_W   = 32;
   localparam int PORT_W = 8;
   localparam int STS_W  = 2;
   localparam int SUB_W  = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_LEARN    = 3'd0,
      REQ_BIND     = 3'd1,
      REQ_LOOK_MAC = 3'd2,
      REQ_LOOK_IP  = 3'd3,
      REQ_LOGICAL  = 3'd4,
      REQ_PHYSICAL = 3'd5
   } req_code_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 2'd0,
      STS_PRESENT   = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_code_type;

   typedef enum logic [SUB_W-1:0] {
      SUB_DIFFERENT = 2'd0,
      SUB_SAME      = 2'd1,
      SUB_UNKNOWN   = 2'd2
   } subnet_code_type;

   typedef enum logic [1:0] {
      KEY_MAC = 2'd0,
      KEY_IPA = 2'd1,
      KEY_IPB = 2'd2
   } key_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [MAC_W-1:0]  host_mac;
      logic [IP_W-1:0]   ip_a;
      logic [IP_W-1:0]   ip_b;
      logic [IP_W-1:0]   mask_in;
      logic [PORT_W-1:0] recv_port;
   } req_item_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic [PORT_W-1:0] port_out;
      logic [SUB_W-1:0]  subnet_result;
   } rsp_item_type;

   typedef struct packed {
      logic    capture;
      logic    scan_start;
      key_type key;
      logic    scan_run;
      logic    finish;
   } hbt_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic hit;
      logic out_free;
   } hbt_stat_type;

endpackage

[design/hbt_req_if.sv]
interface hbt_req_if import hbt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [MAC_W-1:0]  host_mac;
   logic [IP_W-1:0]   ip_a;
   logic [IP_W-1:0]   ip_b;
   logic [IP_W-1:0]   mask_in;
   logic [PORT_W-1:0] recv_port;

   modport source (output valid, req_type, host_mac, ip_a, ip_b, mask_in, recv_port,
                   input ready);
   modport sink   (input valid, req_type, host_mac, ip_a, ip_b, mask_in, recv_port,
                   output ready);
endinterface

[design/hbt_rsp_if.sv]
interface hbt_rsp_if import hbt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STS_W-1:0]  status;
   logic [PORT_W-1:0] port_out;
   logic [SUB_W-1:0]  subnet_result;

   modport source (output valid, status, port_out, subnet_result, input ready);
   modport sink   (input valid, status, port_out, subnet_result, output ready);
endinterface

[design/hbt_ctrl.sv]
module hbt_ctrl import hbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [REQ_W-1:0] req_type,
   output logic             req_ready,
   output hbt_cmd_type      cmd,
   input  hbt_stat_type     stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [REQ_W-1:0] op_ff, op_in;
   logic             second_ff, second_in;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      second_in      = second_ff;
      req_ready      = (state_ff == ST_IDLE);
      cmd.capture    = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.key        = KEY_MAC;
      cmd.scan_run   = 1'b0;
      cmd.finish     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = req_type;
               second_in   = 1'b0;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            state_in       = ST_SCAN;
            cmd.scan_start = 1'b1;
            case (op_ff)
               REQ_LEARN, REQ_BIND, REQ_LOOK_MAC: cmd.key = KEY_MAC;
               REQ_LOOK_IP:                       cmd.key = KEY_IPA;
               REQ_LOGICAL:  cmd.key = second_ff ? KEY_IPB : KEY_IPA;
               REQ_PHYSICAL:                      cmd.key = KEY_IPB;
               default: begin
                  // unused request type: answer without touching the table
                  cmd.scan_start = 1'b0;
                  state_in       = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               if (op_ff == REQ_LOGICAL && !stat.hit && !second_ff) begin
                  // fall back to the mask of the second address
                  second_in = 1'b1;
                  state_in  = ST_START;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
      op_ff <= op_in;
   end

endmodule

[design/hbt_datapath.sv]
module hbt_datapath import hbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  hbt_cmd_type  cmd,
   output hbt_stat_type stat,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         rsp_ready
);

   logic [MAC_W-1:0]  mem_mac  [TABLE_DEPTH];
   logic [IP_W-1:0]   mem_ip   [TABLE_DEPTH];
   logic [IP_W-1:0]   mem_mask [TABLE_DEPTH];
   logic [PORT_W-1:0] mem_port [TABLE_DEPTH];

   req_item_type      req_ff;
   key_type           key_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [MAC_W-1:0]  rd_mac_ff;
   logic [IP_W-1:0]   rd_ip_ff;
   logic [IP_W-1:0]   rd_mask_ff;
   logic [PORT_W-1:0] rd_port_ff;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [IP_W-1:0]   hit_mask_ff;
   logic [PORT_W-1:0] hit_port_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              match_now;
   logic              issue;
   logic [IDX_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  ptr_dec;
   logic              do_learn;
   logic              do_bind;
   logic              table_full;

   always_comb begin
      case (key_ff)
         KEY_MAC: match_now = (rd_mac_ff == req_ff.host_mac);
         KEY_IPA: match_now = (rd_ip_ff == req_ff.ip_a);
         KEY_IPB: match_now = (rd_ip_ff == req_ff.ip_b);
         default: match_now = 1'b0;
      endcase
      match_now = match_now && rd_valid_ff;
   end

   // walk from the newest slot down, stop at the first match
   assign ptr_dec     = ptr_ff - CNT_W'(1);
   assign rd_addr     = ptr_dec[IDX_W-1:0];
   assign issue       = cmd.scan_run && (ptr_ff != '0) && !hit_ff && !match_now;
   assign table_full  = (count_ff == CNT_W'(TABLE_DEPTH));
   assign rd_valid_in = issue;

   always_comb begin
      ptr_in = ptr_ff;
      hit_in = hit_ff;
      if (cmd.scan_start) begin
         ptr_in = count_ff;
         hit_in = 1'b0;
      end else begin
         if (issue) ptr_in = ptr_dec;
         if (match_now) hit_in = 1'b1;
      end
   end

   assign stat.scan_done = hit_ff || ((ptr_ff == '0) && !rd_valid_ff);
   assign stat.hit       = hit_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in   = '{status: STS_NOT_FOUND, port_out: '0, subnet_result: SUB_DIFFERENT};
      do_learn = 1'b0;
      do_bind  = 1'b0;
      count_in = count_ff;
      case (req_ff.req_type)
         REQ_LEARN: begin
            if (hit_ff) begin
               rsp_in.status   = STS_PRESENT;
               rsp_in.port_out = hit_port_ff;
            end else if (table_full) begin
               rsp_in.status = STS_FULL;
            end else begin
               rsp_in.status   = STS_OK;
               rsp_in.port_out = req_ff.recv_port;
               do_learn        = cmd.finish;
            end
         end
         REQ_BIND: begin
            if (hit_ff) begin
               rsp_in.status   = STS_OK;
               rsp_in.port_out = hit_port_ff;
               do_bind         = cmd.finish;
            end
         end
         REQ_LOOK_MAC, REQ_LOOK_IP: begin
            if (hit_ff) begin
               rsp_in.status   = STS_OK;
               rsp_in.port_out = hit_port_ff;
            end
         end
         REQ_LOGICAL: begin
            if (hit_ff) begin
               rsp_in.status        = STS_OK;
               rsp_in.port_out      = hit_port_ff;
               rsp_in.subnet_result = ((req_ff.ip_a & hit_mask_ff) ==
                                       (req_ff.ip_b & hit_mask_ff)) ?
                                      SUB_SAME : SUB_DIFFERENT;
            end else begin
               rsp_in.subnet_result = SUB_UNKNOWN;
            end
         end
         REQ_PHYSICAL: begin
            if (hit_ff) begin
               rsp_in.status        = STS_OK;
               rsp_in.port_out      = hit_port_ff;
               rsp_in.subnet_result = (hit_port_ff == req_ff.recv_port) ?
                                      SUB_SAME : SUB_DIFFERENT;
            end
         end
         default: ;
      endcase
      if (do_learn) count_in = count_ff + CNT_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) req_ff <= req_item;
      if (cmd.scan_start) key_ff <= cmd.key;
      if (issue) rd_idx_ff <= rd_addr;
      if (match_now && !cmd.scan_start) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_mask_ff <= rd_mask_ff;
         hit_port_ff <= rd_port_ff;
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_mac_ff  <= mem_mac[rd_addr];
         rd_ip_ff   <= mem_ip[rd_addr];
         rd_mask_ff <= mem_mask[rd_addr];
         rd_port_ff <= mem_port[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (do_learn) begin
         mem_mac[count_ff[IDX_W-1:0]]  <= req_ff.host_mac;
         mem_ip[count_ff[IDX_W-1:0]]   <= '0;
         mem_mask[count_ff[IDX_W-1:0]] <= '0;
         mem_port[count_ff[IDX_W-1:0]] <= req_ff.recv_port;
      end else if (do_bind) begin
         mem_ip[hit_idx_ff]   <= req_ff.ip_a;
         mem_mask[hit_idx_ff] <= req_ff.mask_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[design/host_binding_table.sv]
// Host binding table: learns MAC addresses with their arrival port, binds IPv4
// addresses and masks to them, and answers MAC and IP lookups and subnet checks,
// one request at a time, always with one response item. Each request walks the
// filled slots from the newest down, reading one slot per cycle from the table
// memory (at most TABLE_DEPTH slots), and stops at the first match; a logical
// subnet check whose first address is unknown walks the table twice. The
// response sits in an output register, so the next request is taken while it
// still waits. No clearing pass after reset.
module host_binding_table import hbt_pkg::*; (
   input logic     clock,
   input logic     reset,
   hbt_req_if.sink   req_chan,
   hbt_rsp_if.source rsp_chan
);

   req_item_type req_item;
   rsp_item_type rsp_item;
   hbt_cmd_type  cmd;
   hbt_stat_type stat;
   logic         ready;
   logic         rsp_valid;

   assign req_item = '{req_type:  req_chan.req_type,
                       host_mac:  req_chan.host_mac,
                       ip_a:      req_chan.ip_a,
                       ip_b:      req_chan.ip_b,
                       mask_in:   req_chan.mask_in,
                       recv_port: req_chan.recv_port};

   hbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   hbt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_chan.ready)
   );

   assign req_chan.ready         = ready;
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.status        = rsp_item.status;
   assign rsp_chan.port_out      = rsp_item.port_out;
   assign rsp_chan.subnet_result = rsp_item.subnet_result;

   // a response is only written into a free output register
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.out_free)
      else $error("response written over a pending one");

   // one request at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while another is in progress");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished request not presented");

   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !cmd.scan_run && !cmd.finish && !cmd.capture)
      else $error("scan start overlaps another command");

endmodule

[tb/sv/tb_host_binding_table.sv]
`timescale 1ns / 1ps

module tb_host_binding_table;
   import hbt_pkg::*;

   localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
   localparam logic [MAC_W-1:0] MAC_ONES    = 48'hFFFF_FFFF_FFFF;
   localparam logic [IP_W-1:0]  IP_ONES     = 32'hFFFF_FFFF;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 16;
   localparam int MAC_POOL_N  = 24;
   localparam int IP_POOL_N   = 8;

   typedef struct packed {
      req_item_type req;
      logic         typed;
      rsp_item_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   hbt_req_if req_bus ();
   hbt_rsp_if rsp_bus ();

   host_binding_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // shadow copy of the binding table
   logic [MAC_W-1:0]  known_mac  [TABLE_DEPTH];
   logic [IP_W-1:0]   known_ip   [TABLE_DEPTH];
   logic [IP_W-1:0]   known_mask [TABLE_DEPTH];
   logic [PORT_W-1:0] known_port [TABLE_DEPTH];
   int                known_count;

   rsp_item_type      rsp_owed [$];
   rsp_item_type      rsp_want;
   stim_row_type      directed_rows [$];
   logic [MAC_W-1:0]  mac_pool [MAC_POOL_N];
   logic [IP_W-1:0]   ip_pool  [IP_POOL_N];

   int fail_count;
   int rsp_seen;
   int items_sent;
   int idle_cycles;
   int cycle_count;
   int stall_left;
   int stall_pick;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int newest_mac(logic [MAC_W-1:0] mac);
      for (int i = known_count - 1; i >= 0; i--)
         if (known_mac[i] == mac) return i;
      return -1;
   endfunction

   function automatic int newest_ip(logic [IP_W-1:0] ip);
      for (int i = known_count - 1; i >= 0; i--)
         if (known_ip[i] == ip) return i;
      return -1;
   endfunction

   // work out the answer to one request and update the shadow table
   function automatic rsp_item_type predict_binding(req_item_type r);
      rsp_item_type o;
      int k;
      logic [IP_W-1:0] m;
      o.status        = STS_NOT_FOUND;
      o.port_out      = '0;
      o.subnet_result = SUB_DIFFERENT;
      case (r.req_type)
         REQ_LEARN: begin
            k = newest_mac(r.host_mac);
            if (k >= 0) begin
               o.status   = STS_PRESENT;
               o.port_out = known_port[k];
            end else if (known_count >= TABLE_DEPTH) begin
               o.status = STS_FULL;
            end else begin
               known_mac[known_count]  = r.host_mac;
               known_ip[known_count]   = '0;
               known_mask[known_count] = '0;
               known_port[known_count] = r.recv_port;
               known_count++;
               o.status   = STS_OK;
               o.port_out = r.recv_port;
            end
         end
         REQ_BIND: begin
            k = newest_mac(r.host_mac);
            if (k >= 0) begin
               known_ip[k]   = r.ip_a;
               known_mask[k] = r.mask_in;
               o.status      = STS_OK;
               o.port_out    = known_port[k];
            end
         end
         REQ_LOOK_MAC: begin
            k = newest_mac(r.host_mac);
            if (k >= 0) begin
               o.status   = STS_OK;
               o.port_out = known_port[k];
            end
         end
         REQ_LOOK_IP: begin
            k = newest_ip(r.ip_a);
            if (k >= 0) begin
               o.status   = STS_OK;
               o.port_out = known_port[k];
            end
         end
         REQ_LOGICAL: begin
            k = newest_ip(r.ip_a);
            if (k < 0) k = newest_ip(r.ip_b);
            if (k >= 0) begin
               m = known_mask[k];
               o.subnet_result = ((r.ip_a & m) == (r.ip_b & m)) ? SUB_SAME : SUB_DIFFERENT;
               o.status        = STS_OK;
               o.port_out      = known_port[k];
            end else begin
               o.subnet_result = SUB_UNKNOWN;
            end
         end
         REQ_PHYSICAL: begin
            k = newest_ip(r.ip_b);
            if (k >= 0) begin
               o.subnet_result = (known_port[k] == r.recv_port) ? SUB_SAME : SUB_DIFFERENT;
               o.status        = STS_OK;
               o.port_out      = known_port[k];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic stim_row_type mk_row(logic [REQ_W-1:0] kind, logic [MAC_W-1:0] mac,
                                           logic [IP_W-1:0] ipa, logic [IP_W-1:0] ipb,
                                           logic [IP_W-1:0] mask, logic [PORT_W-1:0] port,
                                           logic typed, logic [STS_W-1:0] sts,
                                           logic [PORT_W-1:0] pout, logic [SUB_W-1:0] sub);
      stim_row_type row;
      row.req.req_type       = kind;
      row.req.host_mac       = mac;
      row.req.ip_a           = ipa;
      row.req.ip_b           = ipb;
      row.req.mask_in        = mask;
      row.req.recv_port      = port;
      row.typed              = typed;
      row.want.status        = sts;
      row.want.port_out      = pout;
      row.want.subnet_result = sub;
      return row;
   endfunction

   function automatic logic [IP_W-1:0] random_ip();
      if ($urandom_range(0, 9) < 7) return ip_pool[$urandom_range(0, IP_POOL_N - 1)];
      return 32'($urandom);
   endfunction

   function automatic req_item_type random_request();
      req_item_type r;
      int pick;
      int j;
      pick = $urandom_range(0, 99);
      if (pick < 12)      r.req_type = REQ_LEARN;
      else if (pick < 30) r.req_type = REQ_BIND;
      else if (pick < 45) r.req_type = REQ_LOOK_MAC;
      else if (pick < 60) r.req_type = REQ_LOOK_IP;
      else if (pick < 78) r.req_type = REQ_LOGICAL;
      else if (pick < 93) r.req_type = REQ_PHYSICAL;
      else if (pick < 96) r.req_type = REQ_SPARE_6;
      else                r.req_type = REQ_SPARE_7;
      if ($urandom_range(0, 3) != 0) r.host_mac = mac_pool[$urandom_range(0, MAC_POOL_N - 1)];
      else                           r.host_mac = {16'($urandom), 32'($urandom)};
      r.ip_a      = random_ip();
      r.ip_b      = random_ip();
      r.recv_port = 8'($urandom);
      if ($urandom_range(0, 1) != 0) r.mask_in = IP_ONES << (32 - $urandom_range(0, 32));
      else                           r.mask_in = 32'($urandom);
      // aim at a bound entry so that the port compare can come out equal
      if (known_count > 0 && $urandom_range(0, 1) != 0) begin
         j = $urandom_range(0, known_count - 1);
         if (r.req_type == REQ_PHYSICAL) begin
            r.ip_b      = known_ip[j];
            r.recv_port = known_port[j];
         end else if (r.req_type == REQ_LOGICAL) begin
            r.ip_a = known_ip[j];
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int v;
      if ((items_sent % 96) < 24) return 0;
      v = $urandom_range(0, 99);
      if (v < 50) return 0;
      if (v < 80) return $urandom_range(1, 3);
      if (v < 94) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(req_item_type r, logic typed, rsp_item_type want);
      int gap;
      rsp_item_type got;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= r.req_type;
      req_bus.host_mac  <= r.host_mac;
      req_bus.ip_a      <= r.ip_a;
      req_bus.ip_b      <= r.ip_b;
      req_bus.mask_in   <= r.mask_in;
      req_bus.recv_port <= r.recv_port;
      do @(posedge clock); while (!req_bus.ready);
      got = predict_binding(r);
      rsp_owed.push_back(typed ? want : got);
      items_sent++;
   endtask

   // hold the sender until every owed item has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (rsp_owed.size() != 0);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR response %0d %s: got %0d, expected %0d", rsp_seen, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_owed.size() == 0) begin
            report_mismatch("arrived with nothing owed", 0, 0);
         end else begin
            rsp_want = rsp_owed.pop_front();
            if (rsp_bus.status !== rsp_want.status)
               report_mismatch("status", rsp_bus.status, rsp_want.status);
            if (rsp_bus.port_out !== rsp_want.port_out)
               report_mismatch("port_out", rsp_bus.port_out, rsp_want.port_out);
            if (rsp_bus.subnet_result !== rsp_want.subnet_result)
               report_mismatch("subnet_result", rsp_bus.subnet_result, rsp_want.subnet_result);
         end
         rsp_seen++;
      end
   end

   // receiver stalls: mostly short, a few long, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_pick = $urandom_range(0, 99);
         if ((cycle_count % 700) >= 150 && stall_pick < 25)
            stall_left = (stall_pick < 22) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      req_item_type r;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = '0;
      req_bus.host_mac  = '0;
      req_bus.ip_a      = '0;
      req_bus.ip_b      = '0;
      req_bus.mask_in   = '0;
      req_bus.recv_port = '0;
      rsp_bus.ready     = 1'b0;
      known_count       = 0;
      fail_count        = 0;
      rsp_seen          = 0;
      items_sent        = 0;
      idle_cycles       = 0;
      cycle_count       = 0;
      stall_left        = 0;
      foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), 32'($urandom)};
      mac_pool[0] = '0;
      mac_pool[1] = MAC_ONES;
      foreach (ip_pool[i]) ip_pool[i] = 32'($urandom);
      ip_pool[0] = '0;
      ip_pool[1] = IP_ONES;

      // empty table, unused codes, extremes, unbound entries, second-operand mask
      directed_rows.push_back(mk_row(REQ_LOOK_MAC, '0, '0, '0, '0, '0,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOOK_MAC, MAC_ONES, '0, '0, '0, '0,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOOK_IP, '0, '0, '0, '0, '0,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOGICAL, '0, '0, IP_ONES, '0, '0,
                                     1'b1, STS_NOT_FOUND, '0, SUB_UNKNOWN));
      directed_rows.push_back(mk_row(REQ_PHYSICAL, '0, '0, IP_ONES, '0, 8'hFF,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_BIND, MAC_ONES, IP_ONES, '0, IP_ONES, '0,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_SPARE_6, MAC_ONES, IP_ONES, IP_ONES, IP_ONES, 8'hFF,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_SPARE_7, '0, '0, '0, '0, '0,
                                     1'b1, STS_NOT_FOUND, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LEARN, MAC_ONES, '0, '0, '0, 8'hFF,
                                     1'b1, STS_OK, 8'hFF, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LEARN, MAC_ONES, '0, '0, '0, 8'h00,
                                     1'b1, STS_PRESENT, 8'hFF, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LEARN, '0, IP_ONES, IP_ONES, IP_ONES, '0,
                                     1'b1, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOOK_IP, '0, '0, '0, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOOK_MAC, MAC_ONES, '0, '0, '0, '0,
                                     1'b1, STS_OK, 8'hFF, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_BIND, MAC_ONES, IP_ONES, '0, IP_ONES, '0,
                                     1'b1, STS_OK, 8'hFF, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOOK_IP, '0, IP_ONES, '0, '0, '0,
                                     1'b1, STS_OK, 8'hFF, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOGICAL, '0, IP_ONES, 32'hFFFF_FFFE, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOGICAL, '0, 32'h1234_5678, IP_ONES, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_BIND, '0, 32'h0A00_0001, '0, 32'hFFFF_FF00, 8'h55,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOGICAL, '0, 32'h0A00_0001, 32'h0A00_00FE, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOGICAL, '0, 32'h0A00_00FE, 32'h0A00_0001, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_PHYSICAL, '0, '0, IP_ONES, '0, 8'hFF,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_PHYSICAL, '0, '0, IP_ONES, '0, 8'h00,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LEARN, 48'h1, '0, '0, '0, 8'h07,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOGICAL, '0, '0, 32'hDEAD_BEEF, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));
      directed_rows.push_back(mk_row(REQ_LOOK_MAC, 48'h1, '0, '0, '0, '0,
                                     1'b0, STS_OK, '0, SUB_DIFFERENT));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      repeat (220) send_request(random_request(), 1'b0, '0);
      wait_drained();

      // fill every slot, then overflow it
      while (known_count < TABLE_DEPTH) begin
         r          = random_request();
         r.req_type = REQ_LEARN;
         r.host_mac = {16'($urandom), 32'($urandom)};
         send_request(r, 1'b0, '0);
      end
      repeat (2) begin
         r          = random_request();
         r.req_type = REQ_LEARN;
         r.host_mac = {16'($urandom), 32'($urandom)};
         send_request(r, 1'b0, '0);
      end
      r          = random_request();
      r.req_type = REQ_LEARN;
      r.host_mac = known_mac[TABLE_DEPTH - 1];
      send_request(r, 1'b0, '0);

      repeat (180) send_request(random_request(), 1'b0, '0);
      req_bus.valid <= 1'b0;

      while (rsp_owed.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
